### hdl/ipv6f_pkg.sv
package ipv6f_pkg;

   // Byte counter width; the counter saturates at all ones
   localparam int COUNT_BITS = 17;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [COUNT_BITS:0]   length_type;

   localparam count_type COUNT_MAX = '1;

   // Header offsets of interest
   localparam count_type OFF_VERSION   = count_type'(0);
   localparam count_type OFF_LEN_HI    = count_type'(4);
   localparam count_type OFF_LEN_LO    = count_type'(5);
   localparam count_type OFF_NEXT_HDR  = count_type'(6);
   localparam count_type OFF_SUM_START = count_type'(8);
   localparam count_type OFF_DEST      = count_type'(24);
   localparam count_type OFF_HDR_END   = count_type'(40);
   localparam count_type OFF_CSUM_HI   = count_type'(56);
   localparam count_type OFF_CSUM_LO   = count_type'(57);

   // Packet length thresholds
   localparam length_type MIN_IPV6_LEN = length_type'(40);
   localparam length_type MIN_ND_LEN   = length_type'(41);
   localparam length_type MIN_TCP_LEN  = length_type'(60);
   localparam length_type HDR_LEN      = length_type'(40);

   localparam logic [15:0] MIN_TCP_PAYLOAD = 16'd20;
   localparam logic [3:0]  IP_VERSION      = 4'd6;
   localparam logic [7:0]  PROTO_TCP       = 8'd6;
   localparam logic [7:0]  PROTO_ICMPV6    = 8'd58;
   localparam logic [7:0]  ND_TYPE_FIRST   = 8'd133;
   localparam logic [7:0]  ND_TYPE_LAST    = 8'd137;
   localparam logic [7:0]  MCAST_PREFIX    = 8'hff;

   typedef enum logic [1:0] {
      VERDICT_FORWARD  = 2'd0,
      VERDICT_NOT_IPV6 = 2'd1,
      VERDICT_MULTICAST = 2'd2,
      VERDICT_NEIGHBOR = 2'd3
   } verdict_type;

   // Packet summary handed from the parser to the checksum fold stage
   typedef struct packed {
      verdict_type verdict;
      logic        rewritten;
      logic [15:0] seen_checksum;
      logic [31:0] sum;
   } finish_type;

endpackage

### hdl/ipv6f_if.sv
// Packet byte channel
interface ipv6f_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Verdict channel
interface ipv6f_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic        checksum_rewritten;
   logic [15:0] prior_csum;
   logic [15:0] fresh_csum;
   logic        csum_differs;

   modport source (output valid, output verdict, output checksum_rewritten,
                   output prior_csum, output fresh_csum, output csum_differs,
                   input ready);
   modport sink (input valid, input verdict, input checksum_rewritten,
                 input prior_csum, input fresh_csum, input csum_differs,
                 output ready);
endinterface

### hdl/ipv6f_parse.sv
module ipv6f_parse import ipv6f_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ipv6f_req_if.sink  req_chan,
   input  logic       fin_ready,
   output logic       fin_valid,
   output finish_type fin
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_last_ff, in_last_in;

   count_type   count_ff, count_in;
   logic [31:0] sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [3:0]  ver_ff, ver_in;
   logic [7:0]  nh_ff, nh_in;
   logic [15:0] plen_ff, plen_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  icmp_ff, icmp_in;
   logic [15:0] csum_ff, csum_in;

   logic        commit;
   count_type   off;
   length_type  off_ext;
   length_type  pkt_len;
   length_type  end_off;
   length_type  tcp_end;
   logic [7:0]  word_lo;
   logic        summed;
   logic [16:0] addend;

   // A byte leaves the input register unless it ends a packet and the fold stage is full
   assign commit         = in_valid_ff && (!in_last_ff || fin_ready);
   assign req_chan.ready = !in_valid_ff || commit;
   assign fin_valid      = in_valid_ff && in_last_ff;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.data_byte;
         in_last_in  = req_chan.last_byte;
      end
   end

   // Capture header fields and accumulate the ones'-complement words
   always_comb begin
      off     = count_ff;
      off_ext = length_type'(off);
      pkt_len = off_ext + length_type'(1);
      end_off = HDR_LEN + length_type'(plen_ff);

      ver_in  = ver_ff;
      nh_in   = nh_ff;
      plen_in = plen_ff;
      dest_in = dest_ff;
      icmp_in = icmp_ff;
      csum_in = csum_ff;
      pend_in = pend_ff;
      word_lo = in_byte_ff;
      addend  = '0;

      if (off == OFF_VERSION)  ver_in         = in_byte_ff[7:4];
      if (off == OFF_LEN_HI)   plen_in[15:8]  = in_byte_ff;
      if (off == OFF_LEN_LO)   plen_in[7:0]   = in_byte_ff;
      if (off == OFF_NEXT_HDR) nh_in          = in_byte_ff;
      if (off == OFF_DEST)     dest_in        = in_byte_ff;
      if (off == OFF_HDR_END)  icmp_in        = in_byte_ff;
      if (off == OFF_CSUM_HI) begin
         csum_in[15:8] = in_byte_ff;
         word_lo       = '0;
      end
      if (off == OFF_CSUM_LO) begin
         csum_in[7:0] = in_byte_ff;
         word_lo      = '0;
      end

      // Pseudo-header length and protocol go in once the length is known
      if (off == OFF_NEXT_HDR) begin
         addend = 17'(plen_ff) + 17'(PROTO_TCP);
      end

      summed = (off >= OFF_SUM_START) && ((off < OFF_HDR_END) || (off_ext < end_off));
      if (summed) begin
         if (!off[0]) begin
            if ((off >= OFF_HDR_END) && (pkt_len == end_off)) begin
               addend = 17'({word_lo, 8'h00});
            end else begin
               pend_in = word_lo;
            end
         end else begin
            addend = 17'({pend_ff, word_lo});
         end
      end

      sum_in   = sum_ff + 32'(addend);
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + count_type'(1);
   end

   // Verdict from the fields as they stand after this byte
   always_comb begin
      tcp_end           = HDR_LEN + length_type'(plen_in);
      fin.rewritten     = 1'b0;
      fin.seen_checksum = csum_in;
      fin.sum           = sum_in;
      if ((pkt_len < MIN_IPV6_LEN) || (ver_in != IP_VERSION)) begin
         fin.verdict = VERDICT_NOT_IPV6;
      end else if (dest_in == MCAST_PREFIX) begin
         fin.verdict = VERDICT_MULTICAST;
      end else if ((pkt_len >= MIN_ND_LEN) && (nh_in == PROTO_ICMPV6) &&
                   (icmp_in >= ND_TYPE_FIRST) && (icmp_in <= ND_TYPE_LAST)) begin
         fin.verdict = VERDICT_NEIGHBOR;
      end else begin
         fin.verdict   = VERDICT_FORWARD;
         fin.rewritten = (pkt_len >= MIN_TCP_LEN) && (nh_in == PROTO_TCP) &&
                         (plen_in >= MIN_TCP_PAYLOAD) && (pkt_len >= tcp_end);
      end
   end

   // Input stage registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Packet state: advance on each byte, clear after the final one
   always_ff @(posedge clock) begin
      if (reset || (commit && in_last_ff)) begin
         count_ff <= '0;
         sum_ff   <= '0;
         pend_ff  <= '0;
         ver_ff   <= '0;
         nh_ff    <= '0;
         plen_ff  <= '0;
         dest_ff  <= '0;
         icmp_ff  <= '0;
         csum_ff  <= '0;
      end else if (commit) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
         ver_ff   <= ver_in;
         nh_ff    <= nh_in;
         plen_ff  <= plen_in;
         dest_ff  <= dest_in;
         icmp_ff  <= icmp_in;
         csum_ff  <= csum_in;
      end
   end

endmodule

### hdl/ipv6_filter_tcp_checksum.sv
// IPv6 egress filter with TCP checksum recomputation.
// Each verdict passes through the fold and result registers. Throughput: one packet byte
// per cycle unless a final byte waits on the fold stage; one 32-bit checksum add a byte.
// A stalled result holds in the output register while further bytes keep flowing in.
// Reset (synchronous, active high) empties all stages and clears the packet state.
module ipv6_filter_tcp_checksum import ipv6f_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ipv6f_req_if.sink    req_chan,
   ipv6f_rsp_if.source  rsp_chan
);

   logic        fin_valid;
   logic        fin_ready;
   finish_type  fin;

   logic        fold_valid_ff, fold_valid_in;
   finish_type  fold_ff, fold_in;

   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;
   logic        rewritten_ff, rewritten_in;
   logic [15:0] old_ff, old_in;
   logic [15:0] new_ff, new_in;
   logic        changed_ff, changed_in;

   logic        out_free;
   logic [16:0] fold_a;
   logic [15:0] fold_b;
   logic [15:0] new_sum;

   ipv6f_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fin_ready (fin_ready),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   // Stage flow: each stage takes new data when it is empty or draining
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign fin_ready = !fold_valid_ff || out_free;

   always_comb begin
      fold_valid_in = fold_valid_ff;
      fold_in       = fold_ff;
      if (fin_ready) begin
         fold_valid_in = fin_valid;
         fold_in       = fin;
      end
   end

   // Fold the 32-bit sum to 16 bits and complement
   always_comb begin
      fold_a  = 17'(fold_ff.sum[15:0]) + 17'(fold_ff.sum[31:16]);
      fold_b  = fold_a[15:0] + 16'(fold_a[16]);
      new_sum = ~fold_b;
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      rewritten_in = rewritten_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      changed_in   = changed_ff;
      if (out_free) begin
         rsp_valid_in = fold_valid_ff;
         verdict_in   = fold_ff.verdict;
         rewritten_in = fold_ff.rewritten;
         old_in       = fold_ff.rewritten ? fold_ff.seen_checksum : 16'h0000;
         new_in       = fold_ff.rewritten ? new_sum : 16'h0000;
         changed_in   = fold_ff.rewritten && (fold_ff.seen_checksum != new_sum);
      end
   end

   always_ff @(posedge clock) begin
      fold_ff      <= fold_in;
      verdict_ff   <= verdict_in;
      rewritten_ff <= rewritten_in;
      old_ff       <= old_in;
      new_ff       <= new_in;
      changed_ff   <= changed_in;
      if (reset) begin
         fold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fold_valid_ff <= fold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Drive the result channel
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.verdict            = verdict_ff;
   assign rsp_chan.checksum_rewritten = rewritten_ff;
   assign rsp_chan.prior_csum         = old_ff;
   assign rsp_chan.fresh_csum         = new_ff;
   assign rsp_chan.csum_differs       = changed_ff;

   // Checks
   a_rewrite_forward_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rewritten_ff |-> verdict_ff == VERDICT_FORWARD)
      else $error("checksum rewritten on a dropped packet");

   a_zero_when_untouched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rewritten_ff |-> old_ff == 16'h0000 && new_ff == 16'h0000 && !changed_ff)
      else $error("checksum fields set without a rewrite");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> changed_ff == (old_ff != new_ff))
      else $error("changed flag disagrees with checksums");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !fold_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

### sim/ipv6_filter_tcp_checksum_checker.sv
// Watches both channels, predicts each verdict from the accepted bytes and
// compares it with the verdict transaction that the block hands out.
module ipv6_filter_tcp_checksum_checker import ipv6f_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   ipv6f_req_if  req_mon,
   ipv6f_rsp_if  rsp_mon,
   output int    error_count,
   output int    outstanding,
   output int    verdicts_checked,
   output int    drops_checked,
   output int    rewrites_checked,
   output int    unchanged_checked
);

   typedef struct {
      verdict_type verdict;
      logic        rewritten;
      logic [15:0] old_sum;
      logic [15:0] new_sum;
      logic        changed;
   } expect_type;

   expect_type verdict_queue[$];

   // Per-packet state, captured as the bytes pass
   count_type   byte_count;
   logic [31:0] word_total;
   logic [7:0]  held_high;
   logic [3:0]  version_seen;
   logic [7:0]  proto_seen;
   logic [15:0] payload_seen;
   logic [7:0]  dest_prefix;
   logic [7:0]  icmp_seen;
   logic [15:0] csum_seen;

   int fail_tally      = 0;
   int verdict_tally   = 0;
   int drop_tally      = 0;
   int rewrite_tally   = 0;
   int unchanged_tally = 0;

   function automatic void clear_packet();
      byte_count   = '0;
      word_total   = '0;
      held_high    = '0;
      version_seen = '0;
      proto_seen   = '0;
      payload_seen = '0;
      dest_prefix  = '0;
      icmp_seen    = '0;
      csum_seen    = '0;
   endfunction

   // Fold carries back in until none is left, then invert
   function automatic logic [15:0] fold_ones(logic [63:0] total);
      while (total[63:16] != '0) begin
         total = {48'd0, total[15:0]} + {16'd0, total[63:16]};
      end
      return ~total[15:0];
   endfunction

   // Absorb one accepted byte; on the final byte queue the expected verdict
   function automatic void absorb_byte(logic [7:0] b, logic fin);
      int unsigned   off;
      int unsigned   stop;
      logic [7:0]    v;
      length_type    span;
      expect_type    want;

      off  = 32'(byte_count);
      stop = 40 + 32'(payload_seen);
      v    = b;

      case (byte_count)
         OFF_VERSION:  version_seen = b[7:4];
         OFF_LEN_HI:   payload_seen[15:8] = b;
         OFF_LEN_LO:   payload_seen[7:0] = b;
         OFF_NEXT_HDR: proto_seen = b;
         OFF_DEST:     dest_prefix = b;
         OFF_HDR_END:  icmp_seen = b;
         OFF_CSUM_HI: begin
            csum_seen[15:8] = b;
            v = 8'd0;
         end
         OFF_CSUM_LO: begin
            csum_seen[7:0] = b;
            v = 8'd0;
         end
         default: ;
      endcase

      // Sum addresses and covered payload as big-endian words
      if (off >= 8 && (off < 40 || off < stop)) begin
         if (off[0] == 1'b0) begin
            if (off >= 40 && off + 1 == stop)
               word_total += {16'd0, v, 8'd0};
            else
               held_high = v;
         end else begin
            word_total += {16'd0, held_high, v};
         end
      end

      if (byte_count != COUNT_MAX)
         byte_count++;

      if (fin) begin
         span = length_type'(off) + length_type'(1);
         want.verdict   = VERDICT_FORWARD;
         want.rewritten = 1'b0;
         want.old_sum   = '0;
         want.new_sum   = '0;
         want.changed   = 1'b0;
         if (span < MIN_IPV6_LEN || version_seen != IP_VERSION) begin
            want.verdict = VERDICT_NOT_IPV6;
         end else if (dest_prefix == MCAST_PREFIX) begin
            want.verdict = VERDICT_MULTICAST;
         end else if (span >= MIN_ND_LEN && proto_seen == PROTO_ICMPV6 &&
                      icmp_seen >= ND_TYPE_FIRST && icmp_seen <= ND_TYPE_LAST) begin
            want.verdict = VERDICT_NEIGHBOR;
         end else if (span >= MIN_TCP_LEN && proto_seen == PROTO_TCP &&
                      payload_seen >= MIN_TCP_PAYLOAD &&
                      span >= HDR_LEN + length_type'(payload_seen)) begin
            want.rewritten = 1'b1;
            want.old_sum   = csum_seen;
            want.new_sum   = fold_ones(64'(word_total) + 64'(payload_seen) + 64'(PROTO_TCP));
            want.changed   = (want.old_sum != want.new_sum);
         end
         verdict_queue.push_back(want);
         clear_packet();
      end
   endfunction

   // Compare one verdict transaction with the oldest expectation
   function automatic void compare_verdict();
      expect_type want;

      if (verdict_queue.size() == 0) begin
         $error("verdict transaction with no packet outstanding");
         fail_tally++;
         return;
      end
      want = verdict_queue.pop_front();
      verdict_tally++;
      if (want.verdict != VERDICT_FORWARD)
         drop_tally++;
      if (want.rewritten) begin
         rewrite_tally++;
         if (!want.changed)
            unchanged_tally++;
      end
      if (rsp_mon.verdict !== want.verdict) begin
         $error("verdict: expected %0d, got %0d", want.verdict, rsp_mon.verdict);
         fail_tally++;
      end
      if (rsp_mon.checksum_rewritten !== want.rewritten) begin
         $error("checksum_rewritten: expected %0d, got %0d",
                want.rewritten, rsp_mon.checksum_rewritten);
         fail_tally++;
      end
      if (rsp_mon.prior_csum !== want.old_sum) begin
         $error("prior_csum: expected %h, got %h", want.old_sum, rsp_mon.prior_csum);
         fail_tally++;
      end
      if (rsp_mon.fresh_csum !== want.new_sum) begin
         $error("fresh_csum: expected %h, got %h", want.new_sum, rsp_mon.fresh_csum);
         fail_tally++;
      end
      if (rsp_mon.csum_differs !== want.changed) begin
         $error("csum_differs: expected %0d, got %0d",
                want.changed, rsp_mon.csum_differs);
         fail_tally++;
      end
   endfunction

   // Take verdicts before bytes so an unexpected verdict is never matched
   // against a packet that ends on the same edge
   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
         verdict_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            compare_verdict();
         if (req_mon.valid && req_mon.ready)
            absorb_byte(req_mon.data_byte, req_mon.last_byte);
      end
      outstanding       <= verdict_queue.size();
      error_count       <= fail_tally;
      verdicts_checked  <= verdict_tally;
      drops_checked     <= drop_tally;
      rewrites_checked  <= rewrite_tally;
      unchanged_checked <= unchanged_tally;
   end

endmodule

### sim/ipv6_filter_tcp_checksum_tb.sv
module ipv6_filter_tcp_checksum_tb;
   import ipv6f_pkg::*;

   localparam int LONG_HOLD = 200;

   logic clock = 1'b0;
   logic reset;

   ipv6f_req_if req_chan ();
   ipv6f_rsp_if rsp_chan ();

   int check_errors;
   int awaiting;
   int verdicts_seen;
   int drops_seen;
   int rewrites_seen;
   int unchanged_seen;

   // Stimulus bookkeeping
   logic [7:0] frame[$];
   bit         calm          = 1'b0;
   int         holds_asked   = 0;
   int         holds_done    = 0;
   int         bytes_sent    = 0;
   int         frames_sent   = 0;

   ipv6_filter_tcp_checksum dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ipv6_filter_tcp_checksum_checker verdict_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .error_count       (check_errors),
      .outstanding       (awaiting),
      .verdicts_checked  (verdicts_seen),
      .drops_checked     (drops_seen),
      .rewrites_checked  (rewrites_seen),
      .unchanged_checked (unchanged_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hand over one byte, with a random gap first unless the run is calm
   task automatic put_byte(input logic [7:0] d, input logic fin);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.last_byte <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame.size(); i++)
         put_byte(frame[i], i == frame.size() - 1);
      frames_sent++;
   endtask

   // Drop valid and hold until every verdict has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic add_random(input int n);
      repeat (n) frame.push_back(8'($urandom));
   endtask

   function automatic logic [7:0] random_dest();
      return 8'($urandom_range(0, 254));
   endfunction

   task automatic start_header(input logic [3:0] ver, input logic [15:0] plen,
                               input logic [7:0] proto, input logic [7:0] dest0);
      frame.delete();
      add_random(40);
      frame[0]  = {ver, 4'($urandom)};
      frame[4]  = plen[15:8];
      frame[5]  = plen[7:0];
      frame[6]  = proto;
      frame[24] = dest0;
   endtask

   // Work out the checksum a sender would have written, so that some
   // packets arrive already correct
   function automatic logic [15:0] proper_checksum();
      int          plen;
      int          stop;
      int          i;
      logic [31:0] acc;
      logic [7:0]  hi;
      logic [7:0]  lo;

      plen = int'({frame[4], frame[5]});
      stop = 40 + plen;
      acc  = 32'(plen) + 32'(PROTO_TCP);
      for (i = 8; i < stop; i += 2) begin
         hi  = (i == 56) ? 8'd0 : frame[i];
         lo  = (i + 1 >= stop || i + 1 == 57) ? 8'd0 : frame[i + 1];
         acc += {16'd0, hi, lo};
      end
      while (acc[31:16] != '0)
         acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      return ~acc[15:0];
   endfunction

   task automatic tcp_frame(input int plen, input int present, input bit seal);
      logic [15:0] csum;
      start_header(IP_VERSION, 16'(plen), PROTO_TCP, random_dest());
      add_random(present);
      if (seal && present >= plen && frame.size() >= 58) begin
         csum      = proper_checksum();
         frame[56] = csum[15:8];
         frame[57] = csum[7:0];
      end
   endtask

   // Fill a minimal TCP packet with one byte value throughout
   task automatic tcp_filled(input logic [7:0] fill);
      frame.delete();
      repeat (60) frame.push_back(fill);
      frame[0]  = {IP_VERSION, fill[3:0]};
      frame[4]  = 8'd0;
      frame[5]  = 8'd20;
      frame[6]  = PROTO_TCP;
      frame[24] = (fill == MCAST_PREFIX) ? 8'hfe : fill;
   endtask

   task automatic random_frame();
      int kind;
      int plen;
      int present;
      int r;

      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            frame.delete();
            add_random($urandom_range(1, 45));
         end
         1: begin
            start_header(4'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            add_random($urandom_range(0, 40));
         end
         2, 3: begin
            start_header(IP_VERSION, 16'd8, PROTO_ICMPV6,
                         ($urandom_range(0, 7) == 0) ? MCAST_PREFIX : random_dest());
            if ($urandom_range(0, 5) != 0) begin
               frame.push_back(8'($urandom_range(128, 140)));
               add_random($urandom_range(0, 20));
            end
         end
         9: begin
            start_header(IP_VERSION, 16'($urandom_range(0, 40)), PROTO_TCP, random_dest());
            add_random($urandom_range(0, 50));
         end
         default: begin
            plen    = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 21)
                                                 : $urandom_range(20, 80);
            present = plen;
            r       = $urandom_range(0, 9);
            if (r == 0)
               present = $urandom_range(0, plen - 1);
            else if (r <= 2)
               present = plen + $urandom_range(1, 6);
            tcp_frame(plen, present, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 11) == 0)
               frame[24] = MCAST_PREFIX;
         end
      endcase
      send_frame();
   endtask

   // Result side: random stalls, one long hold-off when asked, none when calm
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < holds_asked) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int t;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= 8'd0;
      req_chan.last_byte <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lone bytes and a packet one byte short of a header
      frame = '{8'hff};
      send_frame();
      frame = '{8'h00};
      send_frame();
      start_header(IP_VERSION, 16'd0, PROTO_TCP, 8'h20);
      void'(frame.pop_back());
      send_frame();

      // Wrong version nibble and a multicast destination
      start_header(4'd5, 16'd0, PROTO_TCP, 8'h20);
      send_frame();
      start_header(IP_VERSION, 16'd0, 8'd0, MCAST_PREFIX);
      send_frame();

      // Neighbour discovery bounds, and multicast taking precedence
      for (t = 0; t < 4; t++) begin
         start_header(IP_VERSION, 16'd8, PROTO_ICMPV6, random_dest());
         frame.push_back(8'(132 + t + ((t >= 2) ? 3 : 0)));
         send_frame();
      end
      start_header(IP_VERSION, 16'd8, PROTO_ICMPV6, MCAST_PREFIX);
      frame.push_back(8'd135);
      send_frame();

      // Stall the result side while short packets keep arriving
      holds_asked++;
      repeat (24) begin
         frame = '{8'($urandom)};
         send_frame();
      end
      drain();

      // Random packets, mostly well formed
      while (bytes_sent < 400)
         random_frame();

      // Finish without idling on either side: TCP minimal, odd payload,
      // too short, truncated, correct sum, all ones, oversized length
      calm = 1'b1;
      tcp_frame(20, 20, 1'b0);
      send_frame();
      tcp_frame(21, 21, 1'b1);
      send_frame();
      tcp_frame(19, 19, 1'b0);
      send_frame();
      tcp_frame(40, 20, 1'b0);
      send_frame();
      tcp_frame(20, 20, 1'b1);
      send_frame();
      tcp_filled(8'hff);
      send_frame();
      start_header(IP_VERSION, 16'hffff, PROTO_TCP, random_dest());
      add_random(30);
      send_frame();
      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d packets, %0d bytes: header drops, discovery bounds, TCP sums",
               frames_sent, bytes_sent);
      $display("verdicts checked %0d: %0d drops, %0d rewrites, %0d already correct",
               verdicts_seen, drops_seen, rewrites_seen, unchanged_seen);
      if (check_errors == 0)
         $display("ipv6_filter_tcp_checksum_tb: done, clean");
      else
         $display("ipv6_filter_tcp_checksum_tb: done, errors");
      $finish;
   end

   // Give up long after the slowest correct run would have ended
   initial begin
      #200000;
      $display("ipv6_filter_tcp_checksum_tb: done, errors");
      $finish;
   end

endmodule
